// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define FLR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define FLR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FLR_ASSERT(lbl, clk, rst_n, prop, msg)
`define FLR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hdl/flr_pkg.sv -----
`timescale 1ns / 1ps
package flr_pkg;

    localparam int RECORD_SLOTS  = 8;
    localparam int PAYLOAD_BYTES = 6;

    localparam int IDX_W  = $clog2(RECORD_SLOTS);
    localparam int CNT_W  = $clog2(RECORD_SLOTS + 2);
    localparam int PL_W   = 8 * PAYLOAD_BYTES;
    localparam int WORD_W = 64;

    localparam logic [CNT_W-1:0] FULL_CNT    = CNT_W'(RECORD_SLOTS);
    localparam logic [CNT_W-1:0] UNKNOWN_CNT = CNT_W'(RECORD_SLOTS + 1);

    localparam logic [1:0] REQ_READ    = 2'd0;
    localparam logic [1:0] REQ_APPEND  = 2'd1;
    localparam logic [1:0] REQ_COMPACT = 2'd2;

    localparam logic CFG_KEY_BASE     = 1'b0;
    localparam logic CFG_ERASED_VALUE = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] payload_in;
        logic        op_fault;
    } flr_req_t;

    typedef struct packed {
        logic [7:0] key_base;
        logic [7:0] erased_value;
    } flr_cfg_t;

    typedef struct packed {
        logic             idle;
        logic             done;
        logic [CNT_W-1:0] count;
        logic [PL_W-1:0]  payload;
    } flr_status_t;

endpackage

// ----- hdl/flr_ram.sv -----
`timescale 1ns / 1ps
module flr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/flr_engine.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module flr_engine
    import flr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_take,
    input  flr_req_t    req,
    input  flr_cfg_t    cfg,
    input  logic        res_take,
    output flr_status_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMPACT,
        S_PROG_ISSUE,
        S_PROG_WR,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [1:0]              type_reg, type_next;
    logic                    fault_reg, fault_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        chk_reg, chk_next;
    logic [PL_W-1:0]         buffer_reg, buffer_next;
    logic [PL_W-1:0]         last_pl_reg, last_pl_next;
    logic [RECORD_SLOTS-1:0] erased_reg, erased_next;
    logic [7:0]              fill_reg, fill_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_raddr;
    logic [IDX_W-1:0]  prog_idx;
    logic [IDX_W-1:0]  chk_idx;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] fill_word;
    logic [WORD_W-1:0] scan_word;
    logic [WORD_W-1:0] prog_base;
    logic [WORD_W-1:0] prog_word;
    logic [7:0]        scan_key;
    logic [7:0]        prog_key;
    logic              slot_ok;
    logic              erase_now;

    assign prog_idx  = count_reg[IDX_W-1:0];
    assign chk_idx   = chk_reg[IDX_W-1:0];
    assign fill_word = {8{fill_reg}};

    // erased slots never touch the RAM contents; they read as the fill byte
    assign scan_word = erased_reg[chk_idx] ? fill_word : ram_rdata;
    assign scan_key  = cfg.key_base + 8'(chk_reg);
    assign slot_ok   = (scan_word[7:0] == scan_key)
                    && ((scan_word[7:0] ^ scan_word[15:8]) == 8'hFF);

    assign prog_base = erased_reg[prog_idx] ? fill_word : ram_rdata;
    assign prog_key  = cfg.key_base + 8'(count_reg);

    always_comb
    begin
        prog_word             = prog_base;
        prog_word[7:0]        = prog_key;
        prog_word[16 +: PL_W] = buffer_reg;
        prog_word[15:8]       = ~prog_key;
    end

    assign ram_we = (state_reg == S_PROG_WR);

    // scan issues the next slot while checking the current one
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  ram_raddr = '0;
            S_SCAN:  ram_raddr = IDX_W'(chk_reg + CNT_W'(1));
            default: ram_raddr = prog_idx;
        endcase
    end

    flr_ram #(
        .WIDTH(WORD_W),
        .DEPTH(RECORD_SLOTS)
    ) u_slots (
        .clk  (clk),
        .we   (ram_we),
        .waddr(prog_idx),
        .wdata(prog_word),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        type_next    = type_reg;
        fault_next   = fault_reg;
        count_next   = count_reg;
        chk_next     = chk_reg;
        buffer_next  = buffer_reg;
        last_pl_next = last_pl_reg;
        erased_next  = erased_reg;
        fill_next    = fill_reg;
        erase_now    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    type_next  = req.req_type;
                    fault_next = req.op_fault;
                    chk_next   = '0;
                    unique case (req.req_type)
                        REQ_READ, REQ_COMPACT:
                        begin
                            state_next = S_SCAN;
                        end
                        REQ_APPEND:
                        begin
                            buffer_next = req.payload_in[PL_W-1:0];
                            if (req.op_fault)
                            begin
                                count_next = UNKNOWN_CNT;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                if ((count_reg >= FULL_CNT) || (count_reg == '0))
                                begin
                                    erase_now  = 1'b1;
                                    count_next = '0;
                                end
                                state_next = S_PROG_ISSUE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (slot_ok)
                begin
                    last_pl_next = scan_word[16 +: PL_W];
                    if (chk_reg == FULL_CNT - CNT_W'(1))
                    begin
                        count_next  = FULL_CNT;
                        buffer_next = scan_word[16 +: PL_W];
                        state_next  = (type_reg == REQ_READ) ? S_DONE : S_COMPACT;
                    end
                    else
                    begin
                        chk_next = chk_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    if (scan_word[7:0] == cfg.erased_value)
                    begin
                        count_next = chk_reg;
                        if (chk_reg != '0)
                        begin
                            buffer_next = last_pl_reg;
                        end
                    end
                    else
                    begin
                        count_next = UNKNOWN_CNT;
                    end
                    state_next = (type_reg == REQ_READ) ? S_DONE : S_COMPACT;
                end
            end
            S_COMPACT:
            begin
                if ((count_reg > CNT_W'(1)) && (count_reg <= FULL_CNT))
                begin
                    if (fault_reg)
                    begin
                        count_next = UNKNOWN_CNT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        erase_now  = 1'b1;
                        count_next = '0;
                        state_next = S_PROG_ISSUE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PROG_ISSUE:
            begin
                state_next = S_PROG_WR;
            end
            S_PROG_WR:
            begin
                erased_next[prog_idx] = 1'b0;
                count_next            = count_reg + CNT_W'(1);
                state_next            = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // page erase: mark every slot erased, remember the fill byte
        if (erase_now)
        begin
            erased_next = '1;
            fill_next   = cfg.erased_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            buffer_reg  <= '0;
            erased_reg  <= '1;
            fill_reg    <= '0;
            type_reg    <= REQ_READ;
            fault_reg   <= 1'b0;
            chk_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            buffer_reg  <= buffer_next;
            erased_reg  <= erased_next;
            fill_reg    <= fill_next;
            type_reg    <= type_next;
            fault_reg   <= fault_next;
            chk_reg     <= chk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_pl_reg <= last_pl_next;
    end

    assign stat.idle    = (state_reg == S_IDLE);
    assign stat.done    = (state_reg == S_DONE);
    assign stat.count   = count_reg;
    assign stat.payload = buffer_reg;

    `FLR_ASSERT(a_prog_bumps_count, clk, rst_n, (state_reg == S_PROG_WR) |=> (count_reg == $past(count_reg) + CNT_W'(1)), "program did not advance count")
    `FLR_ASSERT(a_done_count_range, clk, rst_n, (state_reg == S_DONE) |-> (count_reg <= UNKNOWN_CNT), "count out of range")
    `FLR_ASSERT(a_erase_marks_all, clk, rst_n, erase_now |=> (&erased_reg), "erase left a slot unmarked")
    `FLR_ASSERT(a_scan_idx_range, clk, rst_n, (state_reg == S_SCAN) |-> (chk_reg < FULL_CNT), "scan index past page")
    `FLR_ASSERT(a_take_only_idle, clk, rst_n, req_take |-> (state_reg == S_IDLE), "request taken while busy")

endmodule

// ----- hdl/flash_record_log_store.sv -----
`timescale 1ns / 1ps
// Read and compact walk the page with the one-slot-per-cycle scan; compact may then erase the
//   page and rewrite the last record. An append programs one slot, or ends at once on a fault or no-op.
// Throughput: one request in flight; the next is taken the cycle after the result enters
//   the output register.
// Reset (rst_n low, async): count 0, record buffer 0, every slot reads as erased with
//   fill byte 0, both config registers 0, no result pending. No RAM clearing pass.
`include "assert_macros.svh"
module flash_record_log_store
    import flr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // config write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,

    // request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [47:0] payload_in,
    input  logic        op_fault,

    // result channel
    output logic        res_valid,
    input  logic        res_stall,
    output logic        status,
    output logic [3:0]  record_count,
    output logic [47:0] payload_out
);

    logic [7:0]  key_base_reg;
    logic [7:0]  erased_value_reg;

    logic        res_valid_reg, res_valid_next;
    logic        status_reg;
    logic [3:0]  record_count_reg;
    logic [47:0] payload_out_reg;

    flr_req_t    req;
    flr_cfg_t    cfg;
    flr_status_t stat;
    logic        req_take;
    logic        res_load;

    // Engine takes one request at a time; it accepts a new one only from idle.
    assign req_stall = !stat.idle;
    assign req_take  = req_valid && !req_stall;

    assign req.req_type   = req_type;
    assign req.payload_in = payload_in;
    assign req.op_fault   = op_fault;

    assign cfg.key_base     = key_base_reg;
    assign cfg.erased_value = erased_value_reg;

    // Output register frees the engine while the result waits for its transfer.
    assign res_load = stat.done && (!res_valid_reg || !res_stall);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        priority if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    flr_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_take(req_take),
        .req     (req),
        .cfg     (cfg),
        .res_take(res_load),
        .stat    (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_base_reg     <= '0;
            erased_value_reg <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_BASE:     key_base_reg     <= cfg_data;
                    CFG_ERASED_VALUE: erased_value_reg <= cfg_data;
                endcase
            end
        end
    end

    // result payload, loaded on the engine handoff
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg       <= (stat.count > FULL_CNT);
            record_count_reg <= 4'(stat.count);
            payload_out_reg  <= 48'(stat.payload);
        end
    end

    assign res_valid    = res_valid_reg;
    assign status       = status_reg;
    assign record_count = record_count_reg;
    assign payload_out  = payload_out_reg;

    `FLR_ASSERT(a_load_only_free, clk, rst_n, res_load |-> (!res_valid_reg || !res_stall), "result overwritten before transfer")
    `FLR_ASSERT(a_busy_after_take, clk, rst_n, req_take |=> req_stall, "engine idle right after request")
    `FLR_ASSERT_ALWAYS(a_reset_no_result, clk, !rst_n |-> !res_valid, "result valid during reset")

endmodule
